// ===== rtl/core/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and codes for the ring buffer deque: request and status codes,
// controller command and status bundles, and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package rbd_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 10;

  // Request codes; anything else acts as a query
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

  localparam logic signed [DATA_W-1:0] NEG_ONE = -32'sd1;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // latch the request beat
    logic exec;      // update pointers, write or issue a read
    logic capture;   // take registered read data into the end cache
    logic load_out;  // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_read; // valid during exec: a pop needs the new end word
  } stat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   pop_value;
    logic        [STATUS_W-1:0] status;
    logic        [COUNT_W-1:0]  item_count;
    logic                       is_empty;
    logic signed [DATA_W-1:0]   first_value;
    logic signed [DATA_W-1:0]   last_value;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/rbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbd_ctrl
// Sequencer for the deque: takes one request, runs the update and an optional
// store read, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire rbd_pkg::stat_t stat_i,
  output rbd_pkg::cmd_t      cmd_o
);

  localparam int unsigned STATE_W = 2;
  localparam logic [STATE_W-1:0] S_IDLE = 2'd0;
  localparam logic [STATE_W-1:0] S_EXEC = 2'd1;
  localparam logic [STATE_W-1:0] S_READ = 2'd2;
  localparam logic [STATE_W-1:0] S_FIN  = 2'd3;

  logic [STATE_W-1:0] state_q, state_d;
  logic               out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.need_read ? S_READ : S_FIN;
      end
      S_READ: begin
        cmd_o.capture = 1'b1;
        state_d       = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result beat until taken
  always_comb begin
    priority if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // An accepted request always goes to the update step next
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted request did not enter exec");

  // A read step only follows an exec that asked for it
  a_read_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> ($past(state_q) == S_EXEC && $past(stat_i.need_read)))
    else $error("read step without a pending read");

  // Loading a result always presents a beat next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> (out_valid_o && state_q == S_IDLE))
    else $error("result load did not raise valid");

endmodule

`default_nettype wire

// ===== rtl/core/rbd_datapath.sv =====
// ----------------------------------------------------------------------------
// rbd_datapath
// Circular store, head and tail pointers, cached front and back words, and
// the result register of the deque.
// ----------------------------------------------------------------------------
`default_nettype none

module rbd_datapath #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire rbd_pkg::cmd_t                       cmd_i,
  input  wire logic [rbd_pkg::REQ_W-1:0]           req_i,
  input  wire logic signed [rbd_pkg::DATA_W-1:0]   value_i,
  output rbd_pkg::stat_t                           stat_o,
  output rbd_pkg::result_t                         result_o
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = (AW > rbd_pkg::COUNT_W) ? AW : rbd_pkg::COUNT_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] step_up(input logic [AW-1:0] p);
    step_up = (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] step_down(input logic [AW-1:0] p);
    step_down = (p == '0) ? LAST_SLOT : p - AW'(1);
  endfunction

  logic signed [rbd_pkg::DATA_W-1:0] mem [DEPTH];

  logic [rbd_pkg::REQ_W-1:0]         req_q;
  logic signed [rbd_pkg::DATA_W-1:0] value_q;
  logic [AW-1:0]                     head_q, head_d, tail_q, tail_d;
  logic signed [rbd_pkg::DATA_W-1:0] first_q, first_d, last_q, last_d;
  logic signed [rbd_pkg::DATA_W-1:0] popped_q, popped_d;
  logic [rbd_pkg::STATUS_W-1:0]      status_q, status_d;
  logic                              rd_front_q, rd_front_d;
  logic signed [rbd_pkg::DATA_W-1:0] rdata_q;
  rbd_pkg::result_t                  result_q;

  logic [AW-1:0]   cnt;
  logic [AW:0]     wrap_sum;
  logic [CNTW-1:0] cnt_ext;
  logic            full, empty_now;
  logic            wr_en, need_read;
  logic [AW-1:0]   waddr, raddr;

  // Item count from the pointers
  assign wrap_sum  = {1'b0, tail_q} + (AW + 1)'(DEPTH) - {1'b0, head_q};
  assign cnt       = (tail_q >= head_q) ? (tail_q - head_q) : wrap_sum[AW-1:0];
  assign cnt_ext   = CNTW'(cnt);
  assign full      = (cnt == LAST_SLOT);
  assign empty_now = (cnt == '0);

  // Decide the request
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    first_d    = first_q;
    last_d     = last_q;
    popped_d   = rbd_pkg::NEG_ONE;
    status_d   = rbd_pkg::ST_OK;
    rd_front_d = rd_front_q;
    wr_en      = 1'b0;
    waddr      = head_q;
    raddr      = tail_q;
    need_read  = 1'b0;
    unique case (req_q)
      rbd_pkg::REQ_PUSH_FRONT: begin
        if (full) begin
          status_d = rbd_pkg::ST_PUSH_FULL;
        end else begin
          wr_en   = 1'b1;
          waddr   = head_q;
          head_d  = step_down(head_q);
          first_d = value_q;
          if (empty_now) begin
            last_d = value_q;
          end
        end
      end
      rbd_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          status_d = rbd_pkg::ST_PUSH_FULL;
        end else begin
          wr_en  = 1'b1;
          tail_d = step_up(tail_q);
          waddr  = tail_d;
          last_d = value_q;
          if (empty_now) begin
            first_d = value_q;
          end
        end
      end
      rbd_pkg::REQ_POP_FRONT: begin
        if (empty_now) begin
          status_d = rbd_pkg::ST_POP_EMPTY;
        end else begin
          popped_d   = first_q;
          head_d     = step_up(head_q);
          raddr      = step_up(head_d);
          rd_front_d = 1'b1;
          need_read  = (cnt != AW'(1));
        end
      end
      rbd_pkg::REQ_POP_BACK: begin
        if (empty_now) begin
          status_d = rbd_pkg::ST_POP_EMPTY;
        end else begin
          popped_d   = last_q;
          tail_d     = step_down(tail_q);
          raddr      = tail_d;
          rd_front_d = 1'b0;
          need_read  = (cnt != AW'(1));
        end
      end
      default: begin
      end
    endcase
  end

  assign stat_o.need_read = need_read;

  // Latch the request beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q   <= req_i;
      value_q <= value_i;
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  // Store: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem[waddr] <= value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rdata_q <= mem[raddr];
    end
  end

  // Cached end words and per-request status
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      first_q    <= first_d;
      last_q     <= last_d;
      popped_q   <= popped_d;
      status_q   <= status_d;
      rd_front_q <= rd_front_d;
    end else if (cmd_i.capture) begin
      if (rd_front_q) begin
        first_q <= rdata_q;
      end else begin
        last_q <= rdata_q;
      end
    end
  end

  // Result register, loaded from the updated state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      result_q.pop_value   <= popped_q;
      result_q.status      <= status_q;
      result_q.item_count  <= cnt_ext[rbd_pkg::COUNT_W-1:0];
      result_q.is_empty    <= empty_now;
      result_q.first_value <= empty_now ? rbd_pkg::NEG_ONE : first_q;
      result_q.last_value  <= empty_now ? rbd_pkg::NEG_ONE : last_q;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

// ===== rtl/core/ring_buffer_deque_top.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_deque_top
// Double-ended queue of signed 32-bit words in a circular store of DEPTH
// slots, holding at most DEPTH-1 items.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the request code
//   (push front, push back, pop front, pop back, query) and tdata the word
//   to push. Each request gives exactly one result beat on m_axis: tuser is
//   the status (ok, pop on empty, push dropped because full), tdata carries
//   the popped word, item count, empty flag and the front and back words.
//   One request is in work at a time. An accepted request runs the update
//   step, then a read step for a pop that leaves items behind, because the
//   new front or back word is fetched through the store's single
//   registered read port, then loads the result. s_axis_tready returns the
//   cycle after the result is loaded, so a new request is taken only once
//   the last one is through. A stalled result is held in the output register
//   and the next request may be accepted meanwhile, but its result waits
//   until the held beat is taken, and s_axis_tready stays low until then.
//   Reset empties the deque (both pointers to zero) and drops any pending
//   result; the store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_deque_top #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [31:0]   s_axis_tdata,   // [31:0] push_value
  input  wire logic [2:0]    s_axis_tuser,   // [2:0] req_type
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [111:0]       m_axis_tdata,   // [31:0] pop_value, [41:32] item_count,
                                             // [42] is_empty, [74:43] first_value,
                                             // [106:75] last_value, [111:107] zero
  output logic [1:0]         m_axis_tuser    // [1:0] status
);

  rbd_pkg::cmd_t    cmd;
  rbd_pkg::stat_t   stat;
  rbd_pkg::result_t result;

  rbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rbd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .req_i    (s_axis_tuser),
    .value_i  ($signed(s_axis_tdata)),
    .stat_o   (stat),
    .result_o (result)
  );

  // Pack the result beat
  assign m_axis_tdata = {5'd0,
                         result.last_value,
                         result.first_value,
                         result.is_empty,
                         result.item_count,
                         result.pop_value};
  assign m_axis_tuser = result.status;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ring_buffer_deque_top. Request beats go in on the
// slave stream with random gaps; a local deque model predicts every result
// beat, and each beat taken from the master stream is compared field by
// field with the oldest prediction. Directed tests cover the empty deque,
// extreme words, spare request codes and a fill past full; random phases
// then push toward full, drain toward empty or mix all request codes.
// ----------------------------------------------------------------------------
module tb;

  typedef logic [rbd_pkg::REQ_W-1:0] req_t;

  localparam int DEPTH = 1024;
  localparam req_t REQ_CODE_MAX = 3'd7;
  localparam int TOTAL_ITEMS = 1850;
  localparam int WAIT_MAX = 14;
  localparam int EXP_SLOTS = 16;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_e;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [2:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  // Local deque model
  logic signed [rbd_pkg::DATA_W-1:0] dq_store [DEPTH];
  logic [rbd_pkg::COUNT_W-1:0] dq_head;
  logic [rbd_pkg::COUNT_W-1:0] dq_tail;

  // Predictions waiting for their result beat, oldest at exp_rd
  rbd_pkg::result_t exp_fifo [EXP_SLOTS];
  int exp_wr;
  int exp_rd;
  int errors;
  int sent_items;
  bit tx_burst;
  bit rx_burst;

  ring_buffer_deque_top #(.DEPTH(DEPTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, WAIT_MAX);
  endfunction

  function automatic logic [rbd_pkg::COUNT_W-1:0] deque_count();
    return dq_tail - dq_head;
  endfunction

  function automatic int exp_pending();
    return exp_wr - exp_rd;
  endfunction

  // Append a prediction
  task automatic exp_put(input rbd_pkg::result_t res);
    if (exp_pending() >= EXP_SLOTS) begin
      $display("%0t: prediction overflow: expected at most %0d, actual %0d",
               $time, EXP_SLOTS - 1, exp_pending());
      errors++;
    end
    exp_fifo[exp_wr % EXP_SLOTS] = res;
    exp_wr++;
  endtask

  // Take the oldest prediction
  task automatic exp_take(output rbd_pkg::result_t res);
    res = exp_fifo[exp_rd % EXP_SLOTS];
    exp_rd++;
  endtask

  // Apply one request to the model and build its result
  task automatic predict_request(input req_t req,
                                 input logic signed [rbd_pkg::DATA_W-1:0] word,
                                 output rbd_pkg::result_t res);
    logic [rbd_pkg::COUNT_W-1:0] cnt;
    logic [rbd_pkg::COUNT_W-1:0] front_slot;
    res.pop_value = rbd_pkg::NEG_ONE;
    res.status = rbd_pkg::ST_OK;
    cnt = deque_count();
    case (req)
      rbd_pkg::REQ_PUSH_FRONT, rbd_pkg::REQ_PUSH_BACK: begin
        if (cnt >= DEPTH - 1) begin
          res.status = rbd_pkg::ST_PUSH_FULL;
        end else if (req == rbd_pkg::REQ_PUSH_FRONT) begin
          dq_store[dq_head] = word;
          dq_head = dq_head - 1'b1;
        end else begin
          dq_tail = dq_tail + 1'b1;
          dq_store[dq_tail] = word;
        end
      end
      rbd_pkg::REQ_POP_FRONT, rbd_pkg::REQ_POP_BACK: begin
        if (cnt == 0) begin
          res.status = rbd_pkg::ST_POP_EMPTY;
        end else if (req == rbd_pkg::REQ_POP_FRONT) begin
          dq_head = dq_head + 1'b1;
          res.pop_value = dq_store[dq_head];
        end else begin
          res.pop_value = dq_store[dq_tail];
          dq_tail = dq_tail - 1'b1;
        end
      end
      default: ;
    endcase
    cnt = deque_count();
    front_slot = dq_head + 1'b1;
    res.item_count = cnt;
    res.is_empty = (cnt == 0);
    res.first_value = (cnt != 0) ? dq_store[front_slot] : rbd_pkg::NEG_ONE;
    res.last_value = (cnt != 0) ? dq_store[dq_tail] : rbd_pkg::NEG_ONE;
  endtask

  // Drive one request beat, hold it until taken, then record the prediction
  task automatic send_request(input req_t req,
                              input logic signed [rbd_pkg::DATA_W-1:0] word);
    int gap;
    rbd_pkg::result_t res;
    gap = draw_wait(tx_burst);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = word;
    s_axis_tuser = req;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(req, word, res);
    exp_put(res);
    sent_items++;
  endtask

  // Receiver: stall at random before each beat
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      stall = draw_wait(rx_burst);
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    rbd_pkg::result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_pending() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %h / %h",
                 $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        exp_take(exp_r);
        check_field("pop_value", exp_r.pop_value, m_axis_tdata[31:0]);
        check_field("item_count", 32'(exp_r.item_count), 32'(m_axis_tdata[41:32]));
        check_field("is_empty", 32'(exp_r.is_empty), 32'(m_axis_tdata[42]));
        check_field("first_value", exp_r.first_value, m_axis_tdata[74:43]);
        check_field("last_value", exp_r.last_value, m_axis_tdata[106:75]);
        check_field("padding", 32'd0, 32'(m_axis_tdata[111:107]));
        check_field("status", 32'(exp_r.status), 32'(m_axis_tuser));
      end
    end
  end

  // Empty deque: pops, query and the spare request codes
  task automatic test_empty_requests();
    req_t code;
    send_request(rbd_pkg::REQ_POP_FRONT, $urandom);
    send_request(rbd_pkg::REQ_POP_BACK, $urandom);
    send_request(rbd_pkg::REQ_QUERY, $urandom);
    for (code = rbd_pkg::REQ_QUERY + 1'b1; code != '0; code++) begin
      send_request(code, $urandom);
      if (code == REQ_CODE_MAX) break;
    end
  endtask

  // Extreme words at both ends, single-item pops from either side
  task automatic test_extreme_words();
    send_request(rbd_pkg::REQ_PUSH_FRONT, 32'sh8000_0000);
    send_request(rbd_pkg::REQ_PUSH_BACK, 32'sh7fff_ffff);
    send_request(rbd_pkg::REQ_PUSH_FRONT, rbd_pkg::NEG_ONE);
    send_request(rbd_pkg::REQ_PUSH_BACK, 32'sh0000_0000);
    send_request(rbd_pkg::REQ_QUERY, 32'shffff_ffff);
    send_request(rbd_pkg::REQ_POP_FRONT, 32'sh5555_5555);
    send_request(rbd_pkg::REQ_POP_BACK, 32'shaaaa_aaaa);
    send_request(rbd_pkg::REQ_POP_FRONT, $urandom);
    send_request(rbd_pkg::REQ_POP_BACK, $urandom);
    send_request(rbd_pkg::REQ_POP_BACK, $urandom);
    send_request(rbd_pkg::REQ_PUSH_BACK, 32'sh0000_0001);
    send_request(rbd_pkg::REQ_POP_FRONT, $urandom);
    send_request(rbd_pkg::REQ_PUSH_FRONT, 32'sh8000_0001);
    send_request(rbd_pkg::REQ_POP_BACK, $urandom);
    send_request(rbd_pkg::REQ_POP_FRONT, $urandom);
  endtask

  // Fill to capacity, try pushes at both ends around full
  task automatic test_fill_to_full();
    while (deque_count() != DEPTH - 1)
      send_request($urandom_range(0, 1) ? rbd_pkg::REQ_PUSH_BACK : rbd_pkg::REQ_PUSH_FRONT,
                   $urandom);
    send_request(rbd_pkg::REQ_PUSH_FRONT, $urandom);
    send_request(rbd_pkg::REQ_PUSH_BACK, $urandom);
    send_request(rbd_pkg::REQ_QUERY, $urandom);
    send_request(rbd_pkg::REQ_POP_FRONT, $urandom);
    send_request(rbd_pkg::REQ_PUSH_BACK, $urandom);
    send_request(rbd_pkg::REQ_PUSH_FRONT, $urandom);
  endtask

  function automatic req_t pick_request(input phase_e phase);
    int roll;
    req_t push_req;
    req_t pop_req;
    req_t spare_req;
    roll = $urandom_range(0, 99);
    push_req = $urandom_range(0, 1) ? rbd_pkg::REQ_PUSH_BACK : rbd_pkg::REQ_PUSH_FRONT;
    pop_req = $urandom_range(0, 1) ? rbd_pkg::REQ_POP_BACK : rbd_pkg::REQ_POP_FRONT;
    spare_req = req_t'($urandom_range(rbd_pkg::REQ_QUERY, REQ_CODE_MAX));
    case (phase)
      PH_FILL:  return (roll < 85) ? push_req : (roll < 95) ? pop_req : spare_req;
      PH_DRAIN: return (roll < 85) ? pop_req : (roll < 95) ? push_req : spare_req;
      default:  return req_t'($urandom_range(0, REQ_CODE_MAX));
    endcase
  endfunction

  // Random phases with random data and random idling on both sides
  task automatic test_random_phases();
    int len;
    phase_e phase;
    while (sent_items < TOTAL_ITEMS) begin
      phase = phase_e'($urandom_range(0, 2));
      len = $urandom_range(20, 300);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len && sent_items < TOTAL_ITEMS; i++)
        send_request(pick_request(phase), $urandom);
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  initial begin
    errors = 0;
    sent_items = 0;
    exp_wr = 0;
    exp_rd = 0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    dq_head = '0;
    dq_tail = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = rbd_pkg::REQ_QUERY;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_requests();
    test_extreme_words();
    test_fill_to_full();
    test_random_phases();

    // Drain outstanding results, then allow the pipeline to settle
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (exp_pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && exp_pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #8000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
